[sv/vpcd_pkg.sv]
// Package with the result type and the command codes of the plot command decoder.
package vpcd_pkg;

  localparam int unsigned COLOR_TABLE_SIZE = 256;

  localparam logic [4:0] K_LINE   = 5'd0;
  localparam logic [4:0] K_MOVE   = 5'd1;
  localparam logic [4:0] K_STROKE = 5'd2;
  localparam logic [4:0] K_FILL   = 5'd3;
  localparam logic [4:0] K_COLOR  = 5'd4;
  localparam logic [4:0] K_BLACK  = 5'd5;
  localparam logic [4:0] K_DASH   = 5'd6;
  localparam logic [4:0] K_WIDTH  = 5'd7;
  localparam logic [4:0] K_GRAY   = 5'd8;
  localparam logic [4:0] K_RECT   = 5'd9;
  localparam logic [4:0] K_TEXTB  = 5'd10;
  localparam logic [4:0] K_TEXT   = 5'd11;
  localparam logic [4:0] K_SCALE  = 5'd12;
  localparam logic [4:0] K_IMGB   = 5'd13;
  localparam logic [4:0] K_IMGD   = 5'd14;
  localparam logic [4:0] K_IMGE   = 5'd15;
  localparam logic [4:0] K_END    = 5'd16;

  localparam logic [3:0] OP_IDLE  = 4'd0;
  localparam logic [3:0] OP_LINE  = 4'd1;
  localparam logic [3:0] OP_MOVE  = 4'd3;
  localparam logic [3:0] OP_COLOR = 4'd4;
  localparam logic [3:0] OP_TEXT  = 4'd5;
  localparam logic [3:0] OP_TSIZE = 4'd6;
  localparam logic [3:0] OP_STYLE = 4'd7;
  localparam logic [3:0] OP_PSIZE = 4'd8;
  localparam logic [3:0] OP_WIDTH = 4'd9;
  localparam logic [3:0] OP_POLY  = 4'd10;
  localparam logic [3:0] OP_RECT  = 4'd11;
  localparam logic [3:0] OP_ANGLE = 4'd12;
  localparam logic [3:0] OP_IMAGE = 4'd13;
  localparam logic [3:0] OP_SKIP  = 4'd14;

  localparam logic REG_COLOR_COUNT  = 1'b0;
  localparam logic REG_SCALE_ENABLE = 1'b1;

  typedef struct packed {
    logic [4:0]         kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] extent_x;
    logic signed [15:0] extent_y;
    logic signed [19:0] value;
    logic [1:0]         byte_count;
    logic signed [15:0] angle;
  } res_t;

  typedef res_t [2:0] group_t;

endpackage

[sv/vector_plot_command_decoder.sv]
// Top level of the plot command decoder: configuration registers, decoder and result stage.
// A word is taken while in_ready is high; its results appear from the next cycle, one a cycle
// while out_ready is high. Throughput is then one word a cycle while each word gives at most
// one result; a word that gives two or three results holds the input until the single result
// port has handed them all out. Reset (rst_n low, synchronous) clears the parse state and
// restores color_count 8 and scale_enable 1.
module vector_plot_command_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_word,
  input  logic               in_record_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         out_kind,
  output logic signed [15:0] out_pos_x,
  output logic signed [15:0] out_pos_y,
  output logic signed [15:0] out_extent_x,
  output logic signed [15:0] out_extent_y,
  output logic signed [19:0] out_value,
  output logic [1:0]         out_byte_count,
  output logic signed [15:0] out_angle,
  output logic               out_last,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  logic [8:0]       ccount_r;
  logic             scale_r;
  logic             take;
  vpcd_pkg::group_t grp;
  logic [1:0]       grp_n;
  vpcd_pkg::res_t   res;
  logic             room;

  assign cfg_pready = 1'b1;
  assign take = in_valid && in_ready;
  assign in_ready = room;

  always_comb begin
    unique case (cfg_paddr[2])
      vpcd_pkg::REG_COLOR_COUNT:  cfg_prdata = {23'd0, ccount_r};
      vpcd_pkg::REG_SCALE_ENABLE: cfg_prdata = {31'd0, scale_r};
      default:                    cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ccount_r <= 9'd8;
      scale_r <= 1'b1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[2] == vpcd_pkg::REG_COLOR_COUNT) ccount_r <= cfg_pwdata[8:0];
      else scale_r <= cfg_pwdata[0];
    end
  end

  vpcd_decode u_dec (
    .clk(clk),
    .rst_n(rst_n),
    .take(take),
    .word(in_word),
    .record_end(in_record_end),
    .color_count(ccount_r),
    .scale_enable(scale_r),
    .grp(grp),
    .grp_n(grp_n)
  );

  vpcd_out u_out (
    .clk(clk),
    .rst_n(rst_n),
    .load(take && grp_n != 2'd0),
    .grp(grp),
    .grp_n(grp_n),
    .room(room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .res(res),
    .out_last(out_last)
  );

  assign out_kind = res.kind;
  assign out_pos_x = res.pos_x;
  assign out_pos_y = res.pos_y;
  assign out_extent_x = res.extent_x;
  assign out_extent_y = res.extent_y;
  assign out_value = res.value;
  assign out_byte_count = res.byte_count;
  assign out_angle = res.angle;

endmodule

[sv/vpcd_decode.sv]
// Plot word decoder: parse state and up to three results for each accepted word.
module vpcd_decode (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 take,
  input  logic signed [15:0]                   word,
  input  logic                                 record_end,
  input  logic [8:0]                           color_count,
  input  logic                                 scale_enable,
  output vpcd_pkg::group_t                     grp,
  output logic [1:0]                           grp_n
);

  logic [3:0]         phase_r, phase_nxt, phase_inc;
  logic [3:0]         op_r, op_nxt;
  logic signed [15:0] hx_r, hx_nxt, hy_r, hy_nxt, hdx_r, hdx_nxt, hdy_r, hdy_nxt;
  logic [15:0]        skip_r, skip_nxt;
  logic [15:0]        tleft_r, tleft_nxt;
  logic signed [15:0] rot_r, rot_nxt;
  logic               fill_r, fill_nxt;
  logic [1:0]         gray_r, gray_nxt;
  logic               imode_r, imode_nxt, armed_r, armed_nxt;
  logic [31:0]        ileft_r, ileft_nxt;
  logic               pdone_r, pdone_nxt;

  logic               done;
  logic [1:0]         n;
  logic [8:0]         vc;
  logic [4:0]         ep_kind;
  logic [14:0]        wpos, dx;
  logic [27:0]        dprod;
  logic [14:0]        dq, drem_full;
  logic [4:0]         drem;
  logic [3:0]         dash;
  logic [18:0]        wid;
  logic signed [31:0] iprod;
  logic [31:0]        ibytes;
  logic [1:0]         tk;
  logic [15:0]        tl;

  function automatic vpcd_pkg::res_t mk(input logic [4:0] k, input logic signed [15:0] px,
                                        input logic signed [15:0] py,
                                        input logic signed [15:0] ex,
                                        input logic signed [15:0] ey,
                                        input logic signed [19:0] v, input logic [1:0] bc,
                                        input logic signed [15:0] ang);
    vpcd_pkg::res_t r;
    r.kind = k;
    r.pos_x = px;
    r.pos_y = py;
    r.extent_x = ex;
    r.extent_y = ey;
    r.value = v;
    r.byte_count = bc;
    r.angle = ang;
    return r;
  endfunction

  always_comb begin
    vc = (color_count < 9'(vpcd_pkg::COLOR_TABLE_SIZE)) ? color_count
                                                       : 9'(vpcd_pkg::COLOR_TABLE_SIZE);
    ep_kind = fill_r ? vpcd_pkg::K_FILL : vpcd_pkg::K_STROKE;
    wpos = word[15] ? 15'd0 : word[14:0];
    dx = (word[15] || word == 16'sd0) ? 15'd0 : (word[14:0] - 15'd1);
    dprod = 28'(dx) * 28'd6553;
    dq = 15'(dprod >> 16);
    drem_full = dx - 15'(dq * 15'd10);
    drem = drem_full[4:0];
    dash = (drem >= 5'd10) ? 4'(drem - 5'd10) : drem[3:0];
    wid = {wpos, 4'b0} - 19'(wpos);
    iprod = hdx_r * hdy_r;
    ibytes = (iprod > 32'sd0) ? (32'(iprod) + {iprod[30:0], 1'b0}) : 32'd0;
    phase_inc = phase_r + 4'd1;
  end

  always_comb begin
    phase_nxt = phase_r;
    op_nxt = op_r;
    hx_nxt = hx_r;
    hy_nxt = hy_r;
    hdx_nxt = hdx_r;
    hdy_nxt = hdy_r;
    skip_nxt = skip_r;
    tleft_nxt = tleft_r;
    rot_nxt = rot_r;
    fill_nxt = fill_r;
    gray_nxt = gray_r;
    imode_nxt = imode_r;
    armed_nxt = armed_r;
    ileft_nxt = ileft_r;
    pdone_nxt = pdone_r;
    done = 1'b0;
    n = 2'd0;
    grp = '0;
    tk = 2'd0;
    tl = 16'd0;
    if (pdone_r) begin
      n = 2'd0;
    end else if (imode_r) begin
      if (ileft_r != 32'd0) begin
        tk = (ileft_r < 32'd2) ? ileft_r[1:0] : 2'd2;
        grp[n] = mk(vpcd_pkg::K_IMGD, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                    (tk >= 2'd2) ? 20'(word[15:0]) : 20'(word[7:0]), tk, 16'sd0);
        n = n + 2'd1;
        ileft_nxt = ileft_r - 32'(tk);
      end
      if (record_end && ileft_nxt == 32'd0) begin
        grp[n] = mk(vpcd_pkg::K_IMGE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 20'sd0, 2'd0, 16'sd0);
        n = n + 2'd1;
        imode_nxt = 1'b0;
      end
    end else begin
      if (op_r == vpcd_pkg::OP_IDLE) begin
        phase_nxt = 4'd0;
        if (!word[15]) begin
          hx_nxt = word;
          op_nxt = vpcd_pkg::OP_LINE;
        end else if (word == -16'sd1) begin
          op_nxt = vpcd_pkg::OP_IDLE;
        end else if (word == -16'sd2) begin
          grp[n] = mk(vpcd_pkg::K_END, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 20'sd0, 2'd0, 16'sd0);
          n = n + 2'd1;
          pdone_nxt = 1'b1;
        end else if (word >= -16'sd13) begin
          op_nxt = 4'(-word);
        end else begin
          op_nxt = vpcd_pkg::OP_SKIP;
        end
      end else begin
        phase_nxt = phase_inc;
        unique case (op_r)
          vpcd_pkg::OP_LINE: begin
            grp[n] = mk(vpcd_pkg::K_LINE, hx_r, word, 16'sd0, 16'sd0, 20'sd0, 2'd0, 16'sd0);
            n = n + 2'd1;
            done = 1'b1;
          end
          vpcd_pkg::OP_MOVE: begin
            if (phase_inc == 4'd2) hx_nxt = word;
            if (phase_inc >= 4'd3) begin
              grp[n] = mk(ep_kind, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 20'sd0, 2'd0, 16'sd0);
              n = n + 2'd1;
              fill_nxt = 1'b0;
              grp[n] = mk(vpcd_pkg::K_MOVE, hx_r, word, 16'sd0, 16'sd0, 20'sd0, 2'd0,
                          16'sd0);
              n = n + 2'd1;
              done = 1'b1;
            end
          end
          vpcd_pkg::OP_COLOR: begin
            if (phase_inc >= 4'd2) begin
              grp[n] = mk(ep_kind, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 20'sd0, 2'd0, 16'sd0);
              n = n + 2'd1;
              fill_nxt = 1'b0;
              if (!word[15] && word[14:0] < 15'(vc))
                grp[n] = mk(vpcd_pkg::K_COLOR, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 20'(word),
                            2'd0, 16'sd0);
              else
                grp[n] = mk(vpcd_pkg::K_BLACK, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 20'sd0,
                            2'd0, 16'sd0);
              n = n + 2'd1;
              done = 1'b1;
            end
          end
          vpcd_pkg::OP_TEXT: begin
            if (phase_inc == 4'd7) begin
              tl = {1'b0, wpos};
              tleft_nxt = tl;
              grp[n] = mk(vpcd_pkg::K_TEXTB, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 20'(tl), 2'd0,
                          rot_r);
              n = n + 2'd1;
              if (tl == 16'd0) done = 1'b1;
            end else if (phase_inc >= 4'd8) begin
              tk = (tleft_r < 16'd2) ? tleft_r[1:0] : 2'd2;
              phase_nxt = 4'd8;
              grp[n] = mk(vpcd_pkg::K_TEXT, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                          (tk >= 2'd2) ? 20'(word[15:0]) : 20'(word[7:0]), tk, 16'sd0);
              n = n + 2'd1;
              tleft_nxt = tleft_r - 16'(tk);
              if (tleft_nxt == 16'd0) done = 1'b1;
            end
          end
          vpcd_pkg::OP_TSIZE: begin
            if (phase_inc >= 4'd3) done = 1'b1;
          end
          vpcd_pkg::OP_STYLE: begin
            if (phase_inc >= 4'd2) begin
              grp[n] = mk(ep_kind, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 20'sd0, 2'd0, 16'sd0);
              n = n + 2'd1;
              fill_nxt = 1'b0;
              grp[n] = mk(vpcd_pkg::K_DASH, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 20'(dash), 2'd0,
                          16'sd0);
              n = n + 2'd1;
              done = 1'b1;
            end
          end
          vpcd_pkg::OP_PSIZE: begin
            if (phase_inc >= 4'd2) begin
              if (scale_enable) begin
                grp[n] = mk(vpcd_pkg::K_SCALE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 20'(word),
                            2'd0, 16'sd0);
                n = n + 2'd1;
              end
              done = 1'b1;
            end
          end
          vpcd_pkg::OP_WIDTH: begin
            if (phase_inc >= 4'd2) begin
              grp[n] = mk(ep_kind, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 20'sd0, 2'd0, 16'sd0);
              n = n + 2'd1;
              fill_nxt = 1'b0;
              grp[n] = mk(vpcd_pkg::K_WIDTH, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 20'(wid), 2'd0,
                          16'sd0);
              n = n + 2'd1;
              done = 1'b1;
            end
          end
          vpcd_pkg::OP_POLY: begin
            if (phase_inc == 4'd2 && !word[15] && word <= 16'sd2) gray_nxt = word[1:0];
            if (phase_inc == 4'd5) hx_nxt = word;
            if (phase_inc >= 4'd6) begin
              grp[n] = mk(ep_kind, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 20'sd0, 2'd0, 16'sd0);
              n = n + 2'd1;
              grp[n] = mk(vpcd_pkg::K_GRAY, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 20'(gray_r),
                          2'd0, 16'sd0);
              n = n + 2'd1;
              grp[n] = mk(vpcd_pkg::K_MOVE, hx_r, word, 16'sd0, 16'sd0, 20'sd0, 2'd0,
                          16'sd0);
              n = n + 2'd1;
              fill_nxt = 1'b1;
              done = 1'b1;
            end
          end
          vpcd_pkg::OP_RECT: begin
            if (phase_inc == 4'd2) hx_nxt = word;
            if (phase_inc == 4'd3) hy_nxt = word;
            if (phase_inc == 4'd4) hdx_nxt = word;
            if (phase_inc == 4'd5) hdy_nxt = word;
            if (phase_inc >= 4'd6) begin
              if (!word[15] && word[14:0] < 15'(vc))
                grp[n] = mk(vpcd_pkg::K_RECT, hx_r, hy_r, hdx_r, hdy_r, 20'(word), 2'd0,
                            16'sd0);
              else
                grp[n] = mk(vpcd_pkg::K_RECT, hx_r, hy_r, hdx_r, hdy_r,
                            (vc != 9'd0) ? 20'(vc - 9'd1) : 20'sd0, 2'd0, 16'sd0);
              n = n + 2'd1;
              done = 1'b1;
            end
          end
          vpcd_pkg::OP_ANGLE: begin
            if (phase_inc >= 4'd2) begin
              rot_nxt = word;
              done = 1'b1;
            end
          end
          vpcd_pkg::OP_IMAGE: begin
            if (phase_inc == 4'd1) hdx_nxt = word;
            if (phase_inc == 4'd2) hdy_nxt = word;
            if (phase_inc == 4'd3) hx_nxt = word;
            if (phase_inc >= 4'd4) begin
              hy_nxt = word;
              ileft_nxt = ibytes;
              armed_nxt = 1'b1;
              grp[n] = mk(vpcd_pkg::K_IMGB, hx_r, word, hdx_r, hdy_r, 20'sd0, 2'd0, 16'sd0);
              n = n + 2'd1;
              done = 1'b1;
            end
          end
          default: begin
            if (phase_inc == 4'd1) begin
              if (word <= 16'sd0) done = 1'b1;
              else skip_nxt = 16'(word);
            end else begin
              phase_nxt = 4'd2;
              if (skip_r != 16'd0) skip_nxt = skip_r - 16'd1;
              if (skip_nxt == 16'd0) done = 1'b1;
            end
          end
        endcase
      end
      if (done) begin
        op_nxt = vpcd_pkg::OP_IDLE;
        phase_nxt = 4'd0;
      end
      if (record_end) begin
        op_nxt = vpcd_pkg::OP_IDLE;
        phase_nxt = 4'd0;
        skip_nxt = 16'd0;
        tleft_nxt = 16'd0;
        if (armed_nxt && !pdone_nxt) begin
          imode_nxt = 1'b1;
          armed_nxt = 1'b0;
        end
      end
    end
    grp_n = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 4'd0;
      op_r <= vpcd_pkg::OP_IDLE;
      hx_r <= 16'sd0;
      hy_r <= 16'sd0;
      hdx_r <= 16'sd0;
      hdy_r <= 16'sd0;
      skip_r <= 16'd0;
      tleft_r <= 16'd0;
      rot_r <= 16'sd0;
      fill_r <= 1'b0;
      gray_r <= 2'd0;
      imode_r <= 1'b0;
      armed_r <= 1'b0;
      ileft_r <= 32'd0;
      pdone_r <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt;
      op_r <= op_nxt;
      hx_r <= hx_nxt;
      hy_r <= hy_nxt;
      hdx_r <= hdx_nxt;
      hdy_r <= hdy_nxt;
      skip_r <= skip_nxt;
      tleft_r <= tleft_nxt;
      rot_r <= rot_nxt;
      fill_r <= fill_nxt;
      gray_r <= gray_nxt;
      imode_r <= imode_nxt;
      armed_r <= armed_nxt;
      ileft_r <= ileft_nxt;
      pdone_r <= pdone_nxt;
    end
  end

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(pdone_r) |-> pdone_r) else $error("plot end mark cleared");
  a_image_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(imode_r && armed_r)) else $error("image armed while in image mode");
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= 4'd8) else $error("parse phase out of range");

endmodule

[sv/vpcd_out.sv]
// Result register holding one word's group of results and handing them out one by one.
module vpcd_out (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  vpcd_pkg::group_t grp,
  input  logic [1:0]       grp_n,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output vpcd_pkg::res_t   res,
  output logic             out_last
);

  vpcd_pkg::group_t grp_r;
  logic [1:0]       cnt_r, cnt_nxt, idx_r, idx_nxt;
  logic             fire, fin;

  always_comb begin
    out_valid = cnt_r != 2'd0;
    out_last = idx_r == cnt_r - 2'd1;
    fire = out_valid && out_ready;
    fin = fire && out_last;
    room = !out_valid || fin;
    res = grp_r[idx_r];
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (fin) begin
      cnt_nxt = 2'd0;
      idx_nxt = 2'd0;
    end else if (fire) begin
      idx_nxt = idx_r + 2'd1;
    end
    if (load) begin
      cnt_nxt = grp_n;
      idx_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) grp_r <= grp;
  end

  a_idx_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> idx_r < cnt_r) else $error("result index beyond group");
  a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> room) else $error("group loaded over pending results");
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid && idx_r == 2'd0) else $error("loaded group not presented");

endmodule

[bench/vector_plot_command_decoder_tb.sv]
// Self-checking testbench for the vector plot command decoder with its own command predictor.
module vector_plot_command_decoder_tb;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    vpcd_pkg::res_t r;
    logic last;
  } cmd_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_word = '0;
  logic in_record_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [4:0] out_kind;
  logic signed [15:0] out_pos_x, out_pos_y, out_extent_x, out_extent_y, out_angle;
  logic signed [19:0] out_value;
  logic [1:0] out_byte_count;
  logic out_last;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  vector_plot_command_decoder uut (.*);

  always #5 clk = ~clk;

  // Predictor state.
  int unsigned colour_limit = 8;
  bit scale_on = 1'b1;
  int phase = 0;
  logic [3:0] opcode = vpcd_pkg::OP_IDLE;
  int hx = 0, hy = 0, hdx = 0, hdy = 0;
  int skip_left = 0;
  int text_left = 0;
  int rotation = 0;
  bit fill_mark = 1'b0;
  int grey = 0;
  bit image_on = 1'b0;
  bit image_armed = 1'b0;
  longint image_left = 0;
  bit plot_ended = 1'b0;

  cmd_rec_t pending_cmds[$];
  logic [15:0] rec_words[$];
  int errors = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int words_sent = 0;

  task automatic add_cmd(logic [4:0] k, int px, int py, int ex, int ey, int val, int bc,
                         int ang);
    cmd_rec_t c;
    c.r.kind = k;
    c.r.pos_x = px[15:0];
    c.r.pos_y = py[15:0];
    c.r.extent_x = ex[15:0];
    c.r.extent_y = ey[15:0];
    c.r.value = val[19:0];
    c.r.byte_count = bc[1:0];
    c.r.angle = ang[15:0];
    c.last = 1'b0;
    pending_cmds.push_back(c);
  endtask

  task automatic close_path();
    if (fill_mark) begin
      add_cmd(vpcd_pkg::K_FILL, 0, 0, 0, 0, 0, 0, 0);
      fill_mark = 1'b0;
    end else begin
      add_cmd(vpcd_pkg::K_STROKE, 0, 0, 0, 0, 0, 0, 0);
    end
  endtask

  task automatic predict_word(logic [15:0] raw, bit rec_end);
    int w, n0, take, s, vc, idx;
    bit fin;
    longint bytes;
    w = $signed(raw);
    n0 = pending_cmds.size();
    fin = 1'b0;
    vc = (colour_limit < 256) ? colour_limit : 256;
    if (plot_ended) return;
    if (image_on) begin
      if (image_left > 0) begin
        take = (image_left < 2) ? image_left : 2;
        add_cmd(vpcd_pkg::K_IMGD, 0, 0, 0, 0, (take >= 2) ? int'(raw) : int'(raw[7:0]),
                take, 0);
        image_left -= take;
      end
      if (rec_end && image_left == 0) begin
        add_cmd(vpcd_pkg::K_IMGE, 0, 0, 0, 0, 0, 0, 0);
        image_on = 1'b0;
      end
    end else begin
      if (opcode == vpcd_pkg::OP_IDLE) begin
        phase = 0;
        if (w >= 0) begin
          hx = w;
          opcode = vpcd_pkg::OP_LINE;
        end else if (w == -2) begin
          add_cmd(vpcd_pkg::K_END, 0, 0, 0, 0, 0, 0, 0);
          plot_ended = 1'b1;
        end else if (w < -2 && w >= -13) begin
          opcode = 4'(-w);
        end else if (w < -13) begin
          opcode = vpcd_pkg::OP_SKIP;
        end
      end else begin
        phase++;
        case (opcode)
          vpcd_pkg::OP_LINE: begin
            add_cmd(vpcd_pkg::K_LINE, hx, w, 0, 0, 0, 0, 0);
            fin = 1'b1;
          end
          vpcd_pkg::OP_MOVE: begin
            if (phase == 2) hx = w;
            if (phase >= 3) begin
              close_path();
              add_cmd(vpcd_pkg::K_MOVE, hx, w, 0, 0, 0, 0, 0);
              fin = 1'b1;
            end
          end
          vpcd_pkg::OP_COLOR: begin
            if (phase >= 2) begin
              close_path();
              if (w >= 0 && w < vc) add_cmd(vpcd_pkg::K_COLOR, 0, 0, 0, 0, w, 0, 0);
              else add_cmd(vpcd_pkg::K_BLACK, 0, 0, 0, 0, 0, 0, 0);
              fin = 1'b1;
            end
          end
          vpcd_pkg::OP_TEXT: begin
            if (phase == 7) begin
              text_left = (w < 0) ? 0 : w;
              add_cmd(vpcd_pkg::K_TEXTB, 0, 0, 0, 0, text_left, 0, rotation);
              if (text_left == 0) fin = 1'b1;
            end else if (phase >= 8) begin
              phase = 8;
              take = (text_left < 2) ? text_left : 2;
              add_cmd(vpcd_pkg::K_TEXT, 0, 0, 0, 0, (take >= 2) ? int'(raw) : int'(raw[7:0]),
                      take, 0);
              text_left -= take;
              if (text_left == 0) fin = 1'b1;
            end
          end
          vpcd_pkg::OP_TSIZE: begin
            if (phase >= 3) fin = 1'b1;
          end
          vpcd_pkg::OP_STYLE: begin
            if (phase >= 2) begin
              s = (w <= 0) ? 1 : w;
              close_path();
              add_cmd(vpcd_pkg::K_DASH, 0, 0, 0, 0, (s - 1) % 10, 0, 0);
              fin = 1'b1;
            end
          end
          vpcd_pkg::OP_PSIZE: begin
            if (phase >= 2) begin
              if (scale_on) add_cmd(vpcd_pkg::K_SCALE, 0, 0, 0, 0, w, 0, 0);
              fin = 1'b1;
            end
          end
          vpcd_pkg::OP_WIDTH: begin
            if (phase >= 2) begin
              close_path();
              add_cmd(vpcd_pkg::K_WIDTH, 0, 0, 0, 0, ((w < 0) ? 0 : w) * 15, 0, 0);
              fin = 1'b1;
            end
          end
          vpcd_pkg::OP_POLY: begin
            if (phase == 2 && w >= 0 && w <= 2) grey = w;
            if (phase == 5) hx = w;
            if (phase >= 6) begin
              close_path();
              add_cmd(vpcd_pkg::K_GRAY, 0, 0, 0, 0, grey, 0, 0);
              add_cmd(vpcd_pkg::K_MOVE, hx, w, 0, 0, 0, 0, 0);
              fill_mark = 1'b1;
              fin = 1'b1;
            end
          end
          vpcd_pkg::OP_RECT: begin
            if (phase == 2) hx = w;
            if (phase == 3) hy = w;
            if (phase == 4) hdx = w;
            if (phase == 5) hdy = w;
            if (phase >= 6) begin
              idx = w;
              if (idx < 0 || idx >= vc) idx = (vc > 0) ? vc - 1 : 0;
              add_cmd(vpcd_pkg::K_RECT, hx, hy, hdx, hdy, idx, 0, 0);
              fin = 1'b1;
            end
          end
          vpcd_pkg::OP_ANGLE: begin
            if (phase >= 2) begin
              rotation = w;
              fin = 1'b1;
            end
          end
          vpcd_pkg::OP_IMAGE: begin
            if (phase == 1) hdx = w;
            if (phase == 2) hdy = w;
            if (phase == 3) hx = w;
            if (phase >= 4) begin
              bytes = longint'(hdx) * longint'(hdy) * 3;
              hy = w;
              image_left = (bytes > 0) ? bytes : 0;
              image_armed = 1'b1;
              add_cmd(vpcd_pkg::K_IMGB, hx, hy, hdx, hdy, 0, 0, 0);
              fin = 1'b1;
            end
          end
          default: begin
            if (phase == 1) begin
              if (w <= 0) fin = 1'b1;
              else skip_left = w;
            end else begin
              phase = 2;
              if (skip_left > 0) skip_left--;
              if (skip_left == 0) fin = 1'b1;
            end
          end
        endcase
      end
      if (fin) begin
        opcode = vpcd_pkg::OP_IDLE;
        phase = 0;
      end
      if (rec_end) begin
        opcode = vpcd_pkg::OP_IDLE;
        phase = 0;
        skip_left = 0;
        text_left = 0;
        if (image_armed && !plot_ended) begin
          image_on = 1'b1;
          image_armed = 1'b0;
        end
      end
    end
    if (pending_cmds.size() > n0) pending_cmds[$].last = 1'b1;
  endtask

  // Offers one word and waits for it to be taken; returns at a falling edge.
  task automatic send_word(logic [15:0] w, bit rec_end);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    in_record_end <= rec_end;
    do @(posedge clk); while (!in_ready);
    predict_word(w, rec_end);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_record();
    foreach (rec_words[i]) send_word(rec_words[i], i == rec_words.size() - 1);
    rec_words.delete();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(logic regsel, logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {regsel, 2'b00};
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (regsel == vpcd_pkg::REG_COLOR_COUNT) colour_limit = data[8:0];
    else scale_on = data[0];
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic logic [15:0] rnd16();
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [15:0] small_val(int lo, int hi);
    return 16'($urandom_range(0, hi - lo) + lo);
  endfunction

  // Appends one well-formed command with random content to the record being built.
  task automatic add_command(int sel);
    int len;
    case (sel)
      0, 1: begin
        rec_words.push_back(16'($urandom_range(0, 32767)));
        rec_words.push_back(rnd16());
      end
      2: rec_words = {rec_words, 16'hfffd, rnd16(), rnd16(), rnd16()};
      3: rec_words = {rec_words, 16'hfffc, rnd16(), small_val(-3, 260)};
      4: begin
        len = $urandom_range(0, 7) - 1;
        rec_words = {rec_words, 16'hfffb, rnd16(), rnd16(), rnd16(), rnd16(), rnd16(),
                     rnd16(), 16'(len)};
        for (int i = 0; i < (len + 1) / 2; i++) rec_words.push_back(rnd16());
      end
      5: rec_words = {rec_words, 16'hfffa, rnd16(), rnd16()};
      6: rec_words = {rec_words, 16'hfff9, rnd16(), small_val(-5, 40)};
      7: rec_words = {rec_words, 16'hfff8, rnd16(), rnd16()};
      8: rec_words = {rec_words, 16'hfff7, rnd16(), rnd16()};
      9: rec_words = {rec_words, 16'hfff6, rnd16(), small_val(-1, 4), rnd16(), rnd16(),
                      rnd16(), rnd16()};
      10: rec_words = {rec_words, 16'hfff5, rnd16(), rnd16(), rnd16(), rnd16(), rnd16(),
                       small_val(-3, 300)};
      11: rec_words = {rec_words, 16'hfff4, rnd16(), rnd16()};
      12: begin
        len = $urandom_range(0, 4) - 1;
        rec_words = {rec_words, 16'($urandom_range(0, 32754) + 32768), 16'(len)};
        for (int i = 0; i < len; i++) rec_words.push_back(rnd16());
      end
      default: rec_words.push_back(16'hffff);
    endcase
  endtask

  // Sends an image header record followed by the image data records.
  task automatic send_image(int wd, int ht);
    longint n;
    rec_words = {16'hfff3, 16'(wd), 16'(ht), rnd16(), rnd16()};
    send_record();
    n = (image_left + 1) / 2 + $urandom_range(0, 1);
    if (n == 0) n = 1;
    if (n > 2 && $urandom_range(0, 1)) begin
      for (int i = 0; i < n / 2; i++) rec_words.push_back(rnd16());
      send_record();
      n -= n / 2;
    end
    for (int i = 0; i < n; i++) rec_words.push_back(rnd16());
    send_record();
  endtask

  task automatic test_directed();
    rec_words = {16'd0, 16'h8000, 16'h7fff, 16'h7fff, 16'hffff, 16'hfffd, 16'h0, 16'h8000,
                 16'h7fff};
    send_record();
    rec_words = {16'hfffc, 16'h0, 16'hffff, 16'hfffc, 16'h0, 16'd8, 16'hfffc, 16'h0, 16'd7};
    send_record();
    rec_words = {16'hfff9, 16'h0, 16'h0, 16'hfff9, 16'h0, 16'hfffb, 16'hfff9, 16'h0, 16'd25};
    send_record();
    rec_words = {16'hfff7, 16'h0, 16'hfffd, 16'hfff7, 16'h0, 16'h7fff};
    send_record();
    rec_words = {16'hfff6, 16'h0, 16'd5, 16'h0, 16'h0, 16'd1, 16'd2, 16'hfffc, 16'h0, 16'd1};
    send_record();
    rec_words = {16'hfff5, 16'h0, 16'd1, 16'd2, 16'd3, 16'd4, 16'hffff, 16'hfff5, 16'h0,
                 16'd1, 16'd2, 16'd3, 16'd4, 16'd200};
    send_record();
    rec_words = {16'hfff4, 16'h0, 16'd45, 16'hfffb, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                 16'd0, 16'd3, 16'h4241, 16'hff43, 16'hfffb, 16'd0, 16'd0, 16'd0, 16'd0,
                 16'd0, 16'd0, 16'hfff0};
    send_record();
    rec_words = {16'hfff8, 16'h0, 16'd500, 16'hfffa, 16'h0, 16'h0, 16'h8000, 16'd0,
                 16'hfff2, 16'd2, 16'h1, 16'h2};
    send_record();
    // A record that ends in the middle of a rectangle drops it.
    rec_words = {16'hfff5, 16'h0, 16'd1, 16'd2};
    send_record();
    send_image(-2, 3);
    send_image(1, 1);
  endtask

  task automatic test_config_extremes();
    int settings[4] = '{0, 1, 256, 511};
    foreach (settings[i]) begin
      wait_drained();
      cfg_write(vpcd_pkg::REG_COLOR_COUNT, settings[i]);
      cfg_write(vpcd_pkg::REG_SCALE_ENABLE, i[0]);
      rec_words = {16'hfffc, 16'h0, 16'd255, 16'hfff8, 16'h0, 16'd77};
      send_record();
    end
  endtask

  task automatic test_random();
    int cmds, start;
    wait_drained();
    cfg_write(vpcd_pkg::REG_COLOR_COUNT, $urandom_range(1, 256));
    cfg_write(vpcd_pkg::REG_SCALE_ENABLE, $urandom_range(0, 1));
    hold_req = 1'b1;
    start = words_sent;
    while (words_sent - start < 20) begin
      if (words_sent - start > 10) quiet = 1'b1;
      case ($urandom_range(0, 9))
        0: send_image($urandom_range(0, 6) - 2, $urandom_range(0, 5) - 1);
        1: begin
          cmds = $urandom_range(1, 5);
          for (int i = 0; i < cmds; i++) rec_words.push_back(rnd16());
          send_record();
        end
        2: begin
          add_command($urandom_range(2, 12));
          void'(rec_words.pop_back());
          if (rec_words.size() == 0) rec_words.push_back(16'hffff);
          send_record();
        end
        default: begin
          cmds = $urandom_range(1, 4);
          for (int i = 0; i < cmds; i++) add_command($urandom_range(0, 13));
          send_record();
        end
      endcase
    end
  endtask

  task automatic test_end_of_plot();
    rec_words = {16'd5, 16'd6, 16'hfffe, 16'd1, 16'd2, 16'hfffc, 16'h0, 16'd1};
    send_record();
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_config_extremes();
    test_random();
    test_end_of_plot();
    while (pending_cmds.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cmd_rec_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got.r = '{out_kind, out_pos_x, out_pos_y, out_extent_x, out_extent_y, out_value,
                out_byte_count, out_angle};
      got.last = out_last;
      if (pending_cmds.size() == 0) begin
        errors++;
        $display("%0t: expected no word, actual kind %0d", $time, out_kind);
      end else begin
        want = pending_cmds.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: exp kind %0d pos %0d,%0d ext %0d,%0d val %0d bc %0d ang %0d last %0d",
                   $time, want.r.kind, want.r.pos_x, want.r.pos_y, want.r.extent_x,
                   want.r.extent_y, want.r.value, want.r.byte_count, want.r.angle, want.last);
          $display("%0t: act kind %0d pos %0d,%0d ext %0d,%0d val %0d bc %0d ang %0d last %0d",
                   $time, got.r.kind, got.r.pos_x, got.r.pos_y, got.r.extent_x,
                   got.r.extent_y, got.r.value, got.r.byte_count, got.r.angle, got.last);
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule

[sim.f]
sv/vpcd_pkg.sv
sv/vpcd_decode.sv
sv/vpcd_out.sv
sv/vector_plot_command_decoder.sv
bench/vector_plot_command_decoder_tb.sv
